/* hdl/ptsa_pkg.sv */
package ptsa_pkg;

  localparam int unsigned NUM_CHANNELS     = 8;
  localparam int unsigned NUM_TIMERS       = 4;
  localparam int unsigned MAX_CLOCK_SOURCE = 3;
  localparam int unsigned RES_MAX          = 20;
  localparam logic [7:0]  NO_TIMER         = 8'hFF;

  localparam int unsigned CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int unsigned TM_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  // Depth of the queue between the front and the back.
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QP_W   = $clog2(QDEPTH);
  localparam int unsigned QC_W   = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    REQ_ACQUIRE = 2'd0,
    REQ_RELEASE = 2'd1,
    REQ_QUERY   = 2'd2,
    REQ_CLEAR   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_INVALID   = 2'd1,
    ST_BUSY      = 2'd2,
    ST_EXHAUSTED = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DECIDE,
    BK_SCAN,
    BK_DONE
  } bk_state_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [3:0]  channel;
    logic [31:0] freq_hz;
    logic [4:0]  duty_bits;
    logic [2:0]  clk_src;
  } in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] timer_num;
    logic       channel_bound;
  } out_t;

  // A classified request as it travels from the front to the back.
  typedef struct packed {
    req_e            kind;
    logic            ch_ok;
    logic            arg_ok;
    logic [CH_W-1:0] ch;
    logic [31:0]     freq;
    logic [4:0]      res;
    logic [2:0]      clk;
  } op_t;

endpackage

/* hdl/pwm_timer_share_allocator.sv */
// Shares a small pool of PWM timers among channels by reference counting.
// Every request (acquire, release, query, clear) gives exactly one result
// transaction, in request order. Requests enter a two-entry queue and are
// then executed one at a time: query, release, clear and any acquire that
// needs no timer search go from the head of the queue through the idle,
// decide and done states to the result register; an acquire for an unbound
// channel scans the timer table one timer per cycle through its single read
// port. A waiting result does not stop the queue from taking requests until
// the queue is full.
module pwm_timer_share_allocator (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  ptsa_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output ptsa_pkg::out_t out_data_o
);
  import ptsa_pkg::*;

  logic q_push;
  logic q_full;
  logic q_valid;
  logic q_pop;
  op_t  q_op_in;
  op_t  q_op_out;

  ptsa_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_push_o   (q_push),
    .q_op_o     (q_op_in),
    .q_full_i   (q_full)
  );

  ptsa_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .op_i    (q_op_in),
    .full_o  (q_full),
    .valid_o (q_valid),
    .op_o    (q_op_out),
    .pop_i   (q_pop)
  );

  ptsa_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_op_i      (q_op_out),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

/* hdl/ptsa_front.sv */
module ptsa_front (
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  ptsa_pkg::in_t   in_data_i,
  output logic            q_push_o,
  output ptsa_pkg::op_t   q_op_o,
  input  logic            q_full_i
);
  import ptsa_pkg::*;

  logic ch_ok;
  logic prof_ok;
  req_e kind;

  assign kind  = req_e'(in_data_i.req_type);
  assign ch_ok = {1'b0, in_data_i.channel} < 5'(NUM_CHANNELS);

  assign prof_ok = (in_data_i.freq_hz != 32'd0)
                && (in_data_i.duty_bits != 5'd0)
                && (in_data_i.duty_bits <= 5'(RES_MAX))
                && (in_data_i.clk_src <= 3'(MAX_CLOCK_SOURCE));

  always_comb begin
    q_op_o.kind  = kind;
    q_op_o.ch_ok = ch_ok;
    q_op_o.ch    = in_data_i.channel[CH_W-1:0];
    q_op_o.freq  = in_data_i.freq_hz;
    q_op_o.res   = in_data_i.duty_bits;
    q_op_o.clk   = in_data_i.clk_src;
    case (kind)
      REQ_ACQUIRE: q_op_o.arg_ok = ch_ok && prof_ok;
      REQ_CLEAR:   q_op_o.arg_ok = 1'b1;
      default:     q_op_o.arg_ok = ch_ok;
    endcase
  end

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

endmodule

/* hdl/ptsa_queue.sv */
module ptsa_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ptsa_pkg::op_t op_i,
  output logic          full_o,
  output logic          valid_o,
  output ptsa_pkg::op_t op_o,
  input  logic          pop_i
);
  import ptsa_pkg::*;

  op_t             mem_q [QDEPTH];
  logic [QP_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QP_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QC_W-1:0] count_q, count_d;
  logic            do_push;
  logic            do_pop;

  assign full_o  = count_q == QC_W'(QDEPTH);
  assign valid_o = count_q != '0;
  assign op_o    = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QP_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + QP_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QP_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + QP_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + QC_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - QC_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= op_i;
    end
  end

endmodule

/* hdl/ptsa_back.sv */
module ptsa_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  input  ptsa_pkg::op_t  q_op_i,
  output logic           q_pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output ptsa_pkg::out_t out_data_o
);
  import ptsa_pkg::*;

  bk_state_e state_q, state_d;
  op_t       op_q;

  logic [31:0]       tm_freq_q  [NUM_TIMERS];
  logic [4:0]        tm_res_q   [NUM_TIMERS];
  logic [2:0]        tm_clk_q   [NUM_TIMERS];
  logic [4:0]        tm_users_q [NUM_TIMERS];
  logic [NUM_CHANNELS-1:0] ch_valid_q;
  logic [TM_W-1:0]   ch_tmr_q   [NUM_CHANNELS];

  logic [TM_W-1:0] scan_q;
  logic [TM_W-1:0] pick_q;
  logic            pick_found_q;
  logic            pick_live_q;
  logic            bound_hit_q;

  logic            out_valid_q;
  out_t            res_q;
  out_t            res_d;

  logic            cur_bound;
  logic [TM_W-1:0] cur_tmr;
  logic [TM_W-1:0] rd_idx;
  logic [4:0]      rd_users;
  logic            rd_live;
  logic            rd_match;
  logic            scan_last;
  logic            out_free;
  logic            commit;
  logic            acq_take;
  logic            rel_take;
  logic            bound_after;
  logic [TM_W-1:0] tmr_after;
  status_e         status;

  assign cur_bound = op_q.ch_ok && ch_valid_q[op_q.ch];
  assign cur_tmr   = ch_tmr_q[op_q.ch];
  assign scan_last = scan_q == TM_W'(NUM_TIMERS - 1);
  assign out_free  = !out_valid_q || !out_stall_i;

  // One read port on the timer table: the scan position while scanning, the
  // chosen timer when an acquire commits, and otherwise the channel's timer.
  always_comb begin
    if (state_q == BK_SCAN) begin
      rd_idx = scan_q;
    end else if (state_q == BK_DONE && op_q.kind == REQ_ACQUIRE) begin
      rd_idx = pick_q;
    end else begin
      rd_idx = cur_tmr;
    end
  end

  assign rd_users = tm_users_q[rd_idx];
  assign rd_live  = rd_users != 5'd0;
  assign rd_match = (tm_freq_q[rd_idx] == op_q.freq) && (tm_res_q[rd_idx] == op_q.res)
                 && (tm_clk_q[rd_idx] == op_q.clk);

  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (q_valid_i) begin
          state_d = BK_DECIDE;
        end
      end
      BK_DECIDE: begin
        if (op_q.kind == REQ_ACQUIRE && op_q.arg_ok && !cur_bound) begin
          state_d = BK_SCAN;
        end else begin
          state_d = BK_DONE;
        end
      end
      BK_SCAN: begin
        if ((rd_live && rd_match) || scan_last) begin
          state_d = BK_DONE;
        end
      end
      BK_DONE: begin
        if (out_free) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop_o  = (state_q == BK_IDLE) && q_valid_i;
    commit   = (state_q == BK_DONE) && out_free;
    acq_take = commit && op_q.kind == REQ_ACQUIRE && op_q.arg_ok && !cur_bound
            && pick_found_q;
    rel_take = commit && op_q.kind == REQ_RELEASE && op_q.arg_ok && cur_bound;
  end

  // Result of the transaction, seen as the binding after the request.
  always_comb begin
    status      = ST_OK;
    bound_after = 1'b0;
    tmr_after   = cur_tmr;
    case (op_q.kind)
      REQ_ACQUIRE: begin
        bound_after = cur_bound || (op_q.arg_ok && pick_found_q);
        tmr_after   = cur_bound ? cur_tmr : pick_q;
        if (!op_q.arg_ok) begin
          status = ST_INVALID;
        end else if (cur_bound) begin
          status = bound_hit_q ? ST_OK : ST_BUSY;
        end else begin
          status = pick_found_q ? ST_OK : ST_EXHAUSTED;
        end
      end
      REQ_RELEASE: begin
        status = op_q.arg_ok ? ST_OK : ST_INVALID;
      end
      REQ_QUERY: begin
        status      = op_q.arg_ok ? ST_OK : ST_INVALID;
        bound_after = cur_bound;
      end
      default: begin
        status = ST_OK;
      end
    endcase
    res_d.status        = status;
    res_d.timer_num     = bound_after ? 8'(tmr_after) : NO_TIMER;
    res_d.channel_bound = bound_after;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
      ch_valid_q  <= '0;
      for (int i = 0; i < NUM_TIMERS; i++) begin
        tm_users_q[i] <= 5'd0;
      end
    end else begin
      state_q <= state_d;
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (commit && op_q.kind == REQ_CLEAR) begin
        ch_valid_q <= '0;
        for (int i = 0; i < NUM_TIMERS; i++) begin
          tm_users_q[i] <= 5'd0;
        end
      end
      if (acq_take) begin
        tm_users_q[rd_idx]   <= rd_users + 5'd1;
        ch_valid_q[op_q.ch]  <= 1'b1;
      end
      if (rel_take) begin
        if (rd_live) begin
          tm_users_q[rd_idx] <= rd_users - 5'd1;
        end
        ch_valid_q[op_q.ch] <= 1'b0;
      end
    end
  end

  // A timer's profile is only looked at while it has users, so a freed timer
  // keeps its old profile until it is taken again.
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      op_q <= q_op_i;
    end
    if (state_q == BK_DECIDE) begin
      bound_hit_q  <= rd_live && rd_match;
      scan_q       <= '0;
      pick_q       <= '0;
      pick_found_q <= 1'b0;
      pick_live_q  <= 1'b0;
    end
    if (state_q == BK_SCAN) begin
      if (rd_live && rd_match) begin
        pick_q       <= scan_q;
        pick_found_q <= 1'b1;
        pick_live_q  <= 1'b1;
      end else if (!rd_live && !pick_found_q) begin
        pick_q       <= scan_q;
        pick_found_q <= 1'b1;
      end
      if (!scan_last) begin
        scan_q <= scan_q + TM_W'(1);
      end
    end
    if (acq_take) begin
      if (!pick_live_q) begin
        tm_freq_q[rd_idx] <= op_q.freq;
        tm_res_q[rd_idx]  <= op_q.res;
        tm_clk_q[rd_idx]  <= op_q.clk;
      end
      ch_tmr_q[op_q.ch] <= pick_q;
    end
    if (commit) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = res_q;

endmodule

/* tb/pwm_timer_share_allocator_test.sv */
`timescale 1ns / 1ps

module pwm_timer_share_allocator_test;
  import ptsa_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned HOLDOFF_AT    = 300;
  localparam int unsigned HOLDOFF_LEN   = 200;
  localparam int unsigned RANDOM_ITEMS  = 1600;
  localparam int unsigned PROFILE_COUNT = 6;

  typedef struct {
    in_t         data;
    int unsigned gap;
    bit          drain;
  } request_item_t;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic in_stall_o;
  in_t  in_data_i   = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_data_o;

  pwm_timer_share_allocator i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  request_item_t request_q[$];
  out_t          predicted_replies_q[$];
  int unsigned   mismatches;
  int unsigned   replies_seen;
  int unsigned   cycle_cnt;

  // Predicted allocation tables.
  logic [31:0] tmr_freq  [NUM_TIMERS];
  logic [4:0]  tmr_res   [NUM_TIMERS];
  logic [2:0]  tmr_clk   [NUM_TIMERS];
  logic [4:0]  tmr_users [NUM_TIMERS];
  logic        chan_bound[NUM_CHANNELS];
  logic [7:0]  chan_tmr  [NUM_CHANNELS];

  // Stimulus shaping.
  bit          quiet_sender;
  bit          drain_next;
  logic [31:0] pool_freq[PROFILE_COUNT];
  logic [4:0]  pool_res [PROFILE_COUNT];
  logic [2:0]  pool_clk [PROFILE_COUNT];

  // Driver state.
  bit          gap_armed;
  int unsigned gap_left;
  bit          offer;
  int unsigned hold_left;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic void clear_tables();
    for (int t = 0; t < NUM_TIMERS; t++) begin
      tmr_freq[t]  = '0;
      tmr_res[t]   = '0;
      tmr_clk[t]   = '0;
      tmr_users[t] = '0;
    end
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      chan_bound[c] = 1'b0;
      chan_tmr[c]   = NO_TIMER;
    end
  endfunction

  function automatic bit profile_equal(int unsigned t, in_t rq);
    return tmr_freq[t] == rq.freq_hz && tmr_res[t] == rq.duty_bits &&
           tmr_clk[t] == rq.clk_src;
  endfunction

  // Applies one request to the predicted tables and returns the reply.
  function automatic out_t predict_reply(in_t rq);
    status_e     st;
    int unsigned ch;
    int unsigned t;
    int          hit_t;
    int          free_t;
    bit          ch_ok;
    bit          prof_ok;
    out_t        reply;
    ch      = rq.channel;
    ch_ok   = ch < NUM_CHANNELS;
    prof_ok = rq.freq_hz != 0 && rq.duty_bits != 0 &&
              rq.duty_bits <= RES_MAX && rq.clk_src <= MAX_CLOCK_SOURCE;
    st      = ST_OK;
    case (req_e'(rq.req_type))
      REQ_ACQUIRE: begin
        if (!ch_ok || !prof_ok) begin
          st = ST_INVALID;
        end else if (chan_bound[ch]) begin
          t = chan_tmr[ch];
          if (!(t < NUM_TIMERS && profile_equal(t, rq))) st = ST_BUSY;
        end else begin
          // A live timer with the same profile wins over any free timer.
          hit_t  = -1;
          free_t = -1;
          for (int i = 0; i < NUM_TIMERS; i++) begin
            if (hit_t < 0 && tmr_users[i] != 0 && profile_equal(i, rq)) hit_t = i;
            if (free_t < 0 && tmr_users[i] == 0) free_t = i;
          end
          if (hit_t < 0) hit_t = free_t;
          if (hit_t < 0) begin
            st = ST_EXHAUSTED;
          end else begin
            if (tmr_users[hit_t] == 0) begin
              tmr_freq[hit_t] = rq.freq_hz;
              tmr_res[hit_t]  = rq.duty_bits;
              tmr_clk[hit_t]  = rq.clk_src;
            end
            tmr_users[hit_t] = tmr_users[hit_t] + 5'd1;
            chan_bound[ch]   = 1'b1;
            chan_tmr[ch]     = 8'(hit_t);
          end
        end
      end
      REQ_RELEASE: begin
        if (!ch_ok) begin
          st = ST_INVALID;
        end else if (chan_bound[ch]) begin
          t = chan_tmr[ch];
          if (t < NUM_TIMERS && tmr_users[t] != 0) begin
            tmr_users[t] = tmr_users[t] - 5'd1;
            if (tmr_users[t] == 0) begin
              tmr_freq[t] = '0;
              tmr_res[t]  = '0;
              tmr_clk[t]  = '0;
            end
          end
          chan_bound[ch] = 1'b0;
          chan_tmr[ch]   = NO_TIMER;
        end
      end
      REQ_QUERY: begin
        st = ch_ok ? ST_OK : ST_INVALID;
      end
      default: begin
        clear_tables();
      end
    endcase
    reply.status        = st;
    reply.channel_bound = ch_ok && chan_bound[ch];
    reply.timer_num     = reply.channel_bound ? chan_tmr[ch] : NO_TIMER;
    return reply;
  endfunction

  function automatic void add_request(req_e kind, int unsigned ch, logic [31:0] f,
                                      int unsigned r, int unsigned c);
    request_item_t item;
    item.data.req_type  = kind;
    item.data.channel   = 4'(ch);
    item.data.freq_hz   = f;
    item.data.duty_bits = 5'(r);
    item.data.clk_src   = 3'(c);
    item.gap            = quiet_sender ? 0 : $urandom_range(0, 10);
    item.drain          = drain_next;
    drain_next          = 1'b0;
    request_q.push_back(item);
  endfunction

  function automatic void refresh_profiles();
    for (int p = 0; p < PROFILE_COUNT; p++) begin
      pool_freq[p] = $urandom;
      if (pool_freq[p] == 0) pool_freq[p] = 32'd1;
      pool_res[p] = 5'($urandom_range(1, RES_MAX));
      pool_clk[p] = 3'($urandom_range(0, MAX_CLOCK_SOURCE));
    end
    pool_freq[0] = 32'hFFFF_FFFF;
    pool_res[0]  = 5'(RES_MAX);
    pool_clk[0]  = 3'(MAX_CLOCK_SOURCE);
    pool_freq[1] = 32'd1;
    pool_res[1]  = 5'd1;
    pool_clk[1]  = 3'd0;
  endfunction

  function automatic void add_random_request();
    int unsigned pick;
    int unsigned ch;
    int unsigned p;
    pick = $urandom_range(0, 99);
    ch   = ($urandom_range(0, 9) == 0) ? $urandom_range(NUM_CHANNELS, 15)
                                       : $urandom_range(0, NUM_CHANNELS - 1);
    p    = $urandom_range(0, PROFILE_COUNT - 1);
    if (pick < 4) begin
      add_request(req_e'($urandom_range(0, 3)), $urandom_range(0, 15), $urandom,
                  $urandom_range(0, 31), $urandom_range(0, 7));
    end else if (pick < 50) begin
      add_request(REQ_ACQUIRE, ch, pool_freq[p], pool_res[p], pool_clk[p]);
    end else if (pick < 78) begin
      add_request(REQ_RELEASE, ch, $urandom, $urandom_range(0, 31), $urandom_range(0, 7));
    end else if (pick < 96) begin
      add_request(REQ_QUERY, ch, $urandom, $urandom_range(0, 31), $urandom_range(0, 7));
    end else begin
      add_request(REQ_CLEAR, ch, $urandom, $urandom_range(0, 31), $urandom_range(0, 7));
    end
  endfunction

  // Driver: offers queued requests, predicting each one as it is accepted.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
      gap_armed  = 1'b0;
      gap_left   = 0;
    end else begin
      if (in_valid_i && !in_stall_o) predicted_replies_q.push_back(predict_reply(in_data_i));
      if (!in_valid_i || !in_stall_o) begin
        offer = 1'b0;
        if (request_q.size() != 0) begin
          if (!gap_armed) begin
            gap_left  = request_q[0].gap;
            gap_armed = 1'b1;
          end
          if (request_q[0].drain && predicted_replies_q.size() != 0) begin
            // Sender pauses until the block has answered everything.
          end else if (gap_left != 0) begin
            gap_left--;
          end else begin
            offer = 1'b1;
            in_data_i <= request_q[0].data;
            request_q.pop_front();
            gap_armed = 1'b0;
          end
        end
        in_valid_i <= offer;
      end
    end
  end

  // Monitor: checks each reply transaction and draws the next stall.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_left   = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (predicted_replies_q.size() == 0) begin
          $error("reply with none outstanding: status %0d timer_num %0d channel_bound %0d",
                 out_data_o.status, out_data_o.timer_num, out_data_o.channel_bound);
          mismatches++;
        end else begin
          if (out_data_o.status !== predicted_replies_q[0].status) begin
            $error("status: expected %0d, got %0d",
                   predicted_replies_q[0].status, out_data_o.status);
            mismatches++;
          end
          if (out_data_o.timer_num !== predicted_replies_q[0].timer_num) begin
            $error("timer_num: expected %0d, got %0d",
                   predicted_replies_q[0].timer_num, out_data_o.timer_num);
            mismatches++;
          end
          if (out_data_o.channel_bound !== predicted_replies_q[0].channel_bound) begin
            $error("channel_bound: expected %0d, got %0d",
                   predicted_replies_q[0].channel_bound, out_data_o.channel_bound);
            mismatches++;
          end
          void'(predicted_replies_q.pop_front());
        end
        replies_seen++;
        // One long hold-off lets the block fill up and push back on the sender.
        if (replies_seen == HOLDOFF_AT) hold_left = HOLDOFF_LEN;
        else if (replies_seen >= 900 && replies_seen < 1100) hold_left = 0;
        else hold_left = $urandom_range(0, 10);
      end else if (hold_left != 0) begin
        hold_left--;
      end
      out_stall_i <= (hold_left != 0);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("pwm_timer_share_allocator: mismatch");
      $finish;
    end
  end

  initial begin
    clear_tables();
    quiet_sender = 1'b0;
    drain_next   = 1'b0;

    // Directed part: argument checks, sharing, busy, exhaustion and clear.
    add_request(REQ_QUERY, 0, 32'd0, 0, 0);
    add_request(REQ_QUERY, 15, 32'd0, 0, 0);
    add_request(REQ_RELEASE, 3, 32'd0, 0, 0);
    add_request(REQ_RELEASE, 12, 32'd0, 0, 0);
    add_request(REQ_ACQUIRE, NUM_CHANNELS, 32'd100, 10, 0);
    add_request(REQ_ACQUIRE, 1, 32'd0, 10, 0);
    add_request(REQ_ACQUIRE, 1, 32'd100, 0, 0);
    add_request(REQ_ACQUIRE, 1, 32'd100, RES_MAX + 1, 0);
    add_request(REQ_ACQUIRE, 1, 32'd100, 31, 0);
    add_request(REQ_ACQUIRE, 1, 32'd100, 10, MAX_CLOCK_SOURCE + 1);
    add_request(REQ_ACQUIRE, 1, 32'd100, 10, 7);
    add_request(REQ_ACQUIRE, 0, 32'hFFFF_FFFF, RES_MAX, MAX_CLOCK_SOURCE);
    add_request(REQ_ACQUIRE, 1, 32'hFFFF_FFFF, RES_MAX, MAX_CLOCK_SOURCE);
    add_request(REQ_ACQUIRE, 0, 32'hFFFF_FFFF, RES_MAX, MAX_CLOCK_SOURCE);
    add_request(REQ_ACQUIRE, 0, 32'd1, 1, 0);
    add_request(REQ_ACQUIRE, 2, 32'd1, 1, 0);
    add_request(REQ_ACQUIRE, 3, 32'd5000, 8, 1);
    add_request(REQ_ACQUIRE, 4, 32'd25000, 12, 2);
    add_request(REQ_ACQUIRE, 5, 32'd77, 16, 3);
    add_request(REQ_RELEASE, 1, 32'd0, 0, 0);
    add_request(REQ_RELEASE, 0, 32'd0, 0, 0);
    add_request(REQ_ACQUIRE, 5, 32'd77, 16, 3);
    add_request(REQ_QUERY, 5, 32'd0, 0, 0);
    add_request(REQ_QUERY, NUM_CHANNELS - 1, 32'd0, 0, 0);
    add_request(REQ_CLEAR, 0, 32'd0, 0, 0);
    add_request(REQ_QUERY, 2, 32'd0, 0, 0);

    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 250 == 0) refresh_profiles();
      quiet_sender = (n >= 400 && n < 600);
      if (n == 1000) drain_next = 1'b1;
      add_random_request();
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(posedge clk_i);
    while (request_q.size() != 0 || in_valid_i || predicted_replies_q.size() != 0);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("pwm_timer_share_allocator: match");
    end else begin
      $display("pwm_timer_share_allocator: mismatch");
    end
    $finish;
  end

endmodule
